@@ rtl/tpsm_pkg.sv @@
`default_nettype none
package tpsm_pkg;

  // Width of the accepted term count
  localparam int unsigned COUNT_BITS = 31;
  // Width of one residue
  localparam int unsigned RES_BITS   = 50;
  // Bit counter width for the double-and-add loop
  localparam int unsigned BIT_CNT_W  = $clog2(RES_BITS);
  // Modulus 10^15 + 7
  localparam logic [RES_BITS-1:0] SUM_MODULUS = RES_BITS'(64'd1000000000000007);

  // Which matrix product the datapath forms
  typedef enum logic [1:0] {
    MODE_AB  = 2'd0,  // acc  = acc * base
    MODE_BB  = 2'd1,  // base = base * base
    MODE_DOT = 2'd2   // sum  = acc row 3 . start vector
  } mode_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_n;     // capture count, set up matrices
    logic       mul_load;   // load multiplier operands
    logic       mul_step;   // one double-and-add step
    logic       sum_acc;    // add product into running sum
    logic       sum_clr;    // clear running sum after this cycle
    logic       res_wr;     // write sum into result matrix
    logic       commit;     // copy result matrix to target
    logic       exp_shift;  // shift exponent right
    logic       out_load;   // move sum into output register
    mode_e      mode;
    logic [1:0] row;
    logic [1:0] col;
    logic [1:0] kk;
  } tpsm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic low_count;  // count below four
    logic exp_zero;
    logic exp_lsb;
  } tpsm_sts_t;

  // Sum of two reduced residues, reduced again
  function automatic logic [RES_BITS-1:0] mod_add(input logic [RES_BITS-1:0] a,
                                                  input logic [RES_BITS-1:0] b);
    logic [RES_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, SUM_MODULUS}) begin
      s = s - {1'b0, SUM_MODULUS};
    end
    return s[RES_BITS-1:0];
  endfunction

  // Start vector (T3, T2, T1, S3)
  function automatic logic [RES_BITS-1:0] start_val(input logic [1:0] k);
    logic [RES_BITS-1:0] v;
    unique case (k)
      2'd0: v = RES_BITS'(3);
      2'd1: v = RES_BITS'(2);
      2'd2: v = RES_BITS'(1);
      default: v = RES_BITS'(6);
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/tribonacci_prefix_sum_mod_top.sv @@
// Counts below four use fixed answers; others use a 4x4 matrix power with exponent n-3.
// Throughput: one count at a time; set by the single bit-serial modular multiplier.
// Reset: rst_ni asynchronous active low clears the controller; no pending result.
`default_nettype none
module tribonacci_prefix_sum_mod_top import tpsm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [30:0] term_count
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [55:0]      m_axis_tdata_o    // [49:0] sum_mod
);

  tpsm_cmd_t           cmd;
  tpsm_sts_t           sts;
  logic [RES_BITS-1:0] out_data;

  tpsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tpsm_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .count_i    (s_axis_tdata_i[COUNT_BITS-1:0]),
    .sts_o      (sts),
    .out_data_o (out_data)
  );

  assign m_axis_tdata_o = {{(56 - RES_BITS){1'b0}}, out_data};

endmodule
`default_nettype wire

@@ rtl/tpsm_datapath.sv @@
`default_nettype none
module tpsm_datapath import tpsm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tpsm_cmd_t             cmd_i,
  input  wire logic [COUNT_BITS-1:0] count_i,
  output tpsm_sts_t                  sts_o,
  output logic [RES_BITS-1:0]        out_data_o
);

  logic [RES_BITS-1:0]   acc_q  [16];
  logic [RES_BITS-1:0]   base_q [16];
  logic [RES_BITS-1:0]   res_q  [16];
  logic [COUNT_BITS-1:0] exp_q;
  logic                  small_q;
  logic [RES_BITS-1:0]   x_q, y_q, prod_q, sum_q, out_q;
  logic [RES_BITS-1:0]   x_sel, y_sel, dbl, sum_nxt, small_val;
  logic [3:0]            p_idx, q_idx, r_idx;

  assign p_idx = {cmd_i.row, cmd_i.kk};
  assign q_idx = {cmd_i.kk, cmd_i.col};
  assign r_idx = {cmd_i.row, cmd_i.col};

  // Operand selection
  always_comb begin
    unique case (cmd_i.mode)
      MODE_AB: begin
        x_sel = acc_q[p_idx];
        y_sel = base_q[q_idx];
      end
      MODE_BB: begin
        x_sel = base_q[p_idx];
        y_sel = base_q[q_idx];
      end
      MODE_DOT: begin
        x_sel = acc_q[p_idx];
        y_sel = start_val(cmd_i.kk);
      end
      default: begin
        x_sel = '0;
        y_sel = '0;
      end
    endcase
  end

  assign dbl     = mod_add(prod_q, prod_q);
  assign sum_nxt = mod_add(sum_q, prod_q);

  // Fixed answers for counts 0..3
  always_comb begin
    unique case (count_i[1:0])
      2'd0: small_val = RES_BITS'(0);
      2'd1: small_val = RES_BITS'(1);
      2'd2: small_val = RES_BITS'(3);
      default: small_val = RES_BITS'(6);
    endcase
  end

  // Control-side status register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_q <= 1'b0;
      exp_q   <= '0;
    end else if (cmd_i.load_n) begin
      small_q <= (count_i < COUNT_BITS'(4));
      exp_q   <= count_i - COUNT_BITS'(3);
    end else if (cmd_i.exp_shift) begin
      exp_q   <= exp_q >> 1;
    end
  end

  // Matrices, multiplier and running sum
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_n) begin
      for (int e = 0; e < 16; e++) begin
        acc_q[e]  <= ((e / 4) == (e % 4)) ? RES_BITS'(1) : RES_BITS'(0);
        base_q[e] <= RES_BITS'(0);
      end
      base_q[0]  <= RES_BITS'(1);
      base_q[1]  <= RES_BITS'(1);
      base_q[2]  <= RES_BITS'(1);
      base_q[4]  <= RES_BITS'(1);
      base_q[9]  <= RES_BITS'(1);
      base_q[12] <= RES_BITS'(1);
      base_q[13] <= RES_BITS'(1);
      base_q[14] <= RES_BITS'(1);
      base_q[15] <= RES_BITS'(1);
      sum_q      <= (count_i < COUNT_BITS'(4)) ? small_val : RES_BITS'(0);
    end else begin
      if (cmd_i.commit) begin
        for (int e = 0; e < 16; e++) begin
          if (cmd_i.mode == MODE_AB) acc_q[e] <= res_q[e];
          else                       base_q[e] <= res_q[e];
        end
      end
      if (cmd_i.res_wr) res_q[r_idx] <= sum_nxt;
      if (cmd_i.sum_clr)      sum_q <= '0;
      else if (cmd_i.sum_acc) sum_q <= sum_nxt;
    end
    if (cmd_i.mul_load) begin
      x_q    <= x_sel;
      y_q    <= y_sel;
      prod_q <= '0;
    end else if (cmd_i.mul_step) begin
      prod_q <= y_q[RES_BITS-1] ? mod_add(dbl, x_q) : dbl;
      y_q    <= y_q << 1;
    end
    if (cmd_i.out_load) out_q <= sum_q;
  end

  assign sts_o.low_count = small_q;
  assign sts_o.exp_zero  = (exp_q == '0);
  assign sts_o.exp_lsb   = exp_q[0];
  assign out_data_o      = out_q;

endmodule
`default_nettype wire

@@ rtl/tpsm_ctrl.sv @@
`default_nettype none
module tpsm_ctrl import tpsm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire tpsm_sts_t sts_i,
  output tpsm_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SETUP  = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_MLOAD  = 7'b0001000,
    S_MSTEP  = 7'b0010000,
    S_MACC   = 7'b0100000,
    S_COMMIT = 7'b1000000
  } state_e;

  state_e               state_q, state_d;
  mode_e                mode_q, mode_d;
  logic [1:0]           row_q, row_d, col_q, col_d, kk_q, kk_d;
  logic [BIT_CNT_W-1:0] bit_q, bit_d;
  logic                 out_valid_q, out_valid_d;
  logic                 done_q, done_d;
  logic                 out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && !done_q;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    row_d       = row_q;
    col_d       = col_q;
    kk_d        = kk_q;
    bit_d       = bit_q;
    done_d      = done_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.mode  = mode_q;
    cmd_o.row   = row_q;
    cmd_o.col   = col_q;
    cmd_o.kk    = kk_q;

    // Deliver a finished sum once the output register is free
    if (done_q && out_free) begin
      cmd_o.out_load = 1'b1;
      out_valid_d    = 1'b1;
      done_d         = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load_n = 1'b1;
          state_d      = S_SETUP;
        end
      end
      S_SETUP: begin
        if (sts_i.low_count) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        row_d   = 2'd0;
        col_d   = 2'd0;
        kk_d    = 2'd0;
        state_d = S_MLOAD;
        if (sts_i.exp_zero) begin
          mode_d = MODE_DOT;
          row_d  = 2'd3;
        end else if (sts_i.exp_lsb) begin
          mode_d = MODE_AB;
        end else begin
          mode_d = MODE_BB;
        end
      end
      S_MLOAD: begin
        cmd_o.mul_load = 1'b1;
        bit_d          = BIT_CNT_W'(RES_BITS - 1);
        state_d        = S_MSTEP;
      end
      S_MSTEP: begin
        cmd_o.mul_step = 1'b1;
        if (bit_q == '0) state_d = S_MACC;
        else             bit_d   = bit_q - 1'b1;
      end
      S_MACC: begin
        cmd_o.sum_acc = 1'b1;
        state_d       = S_MLOAD;
        if (kk_q != 2'd3) begin
          kk_d = kk_q + 1'b1;
        end else if (mode_q == MODE_DOT) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.res_wr  = 1'b1;
          cmd_o.sum_clr = 1'b1;
          kk_d          = 2'd0;
          col_d         = col_q + 1'b1;
          if (col_q == 2'd3) row_d = row_q + 1'b1;
          if (row_q == 2'd3 && col_q == 2'd3) state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        if (mode_q == MODE_AB) begin
          mode_d  = MODE_BB;
          row_d   = 2'd0;
          col_d   = 2'd0;
          kk_d    = 2'd0;
          state_d = S_MLOAD;
        end else begin
          cmd_o.exp_shift = 1'b1;
          state_d         = S_CHECK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_AB;
      row_q       <= '0;
      col_q       <= '0;
      kk_q        <= '0;
      bit_q       <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      row_q       <= row_d;
      col_q       <= col_d;
      kk_q        <= kk_d;
      bit_q       <= bit_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A held result stays until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("result dropped before transfer");

  // An accepted count always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_SETUP)
    else $error("accepted count not started");

  // The dot product never commits a matrix
  a_commit_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COMMIT |-> mode_q != MODE_DOT)
    else $error("commit in dot mode");

  // Output register load only when it is free
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> out_free)
    else $error("output overwritten");

endmodule
`default_nettype wire
